// ===== src/bpb_pkg.sv =====
// ----------------------------------------------------------------------------
// bpb_pkg: shared types and constants for the bundle primary block parser
// Payload structs, field step codes and the per-field value mask.
// ----------------------------------------------------------------------------
package bpb_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [4:0] STEP_VERSION  = 5'd0;
  localparam logic [4:0] STEP_FLAGS    = 5'd1;
  localparam logic [4:0] STEP_EID_FRST = 5'd3;
  localparam logic [4:0] STEP_EID_LAST = 5'd10;
  localparam logic [4:0] STEP_TIME     = 5'd11;
  localparam logic [4:0] STEP_LIFE     = 5'd13;
  localparam logic [4:0] STEP_DICTLEN  = 5'd14;
  localparam logic [4:0] STEP_DICTBYTE = 5'd15;
  localparam logic [4:0] STEP_FRAGOFF  = 5'd16;
  localparam logic [4:0] STEP_ADULEN   = 5'd17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_header;
  } bpb_in_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [63:0] field_value;
    logic [31:0] dict_index;
    logic        too_long;
    logic        header_done;
    logic [31:0] header_bytes;
  } bpb_out_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } bpb_qstat_t;

  function automatic logic [63:0] field_mask(input logic [4:0] id);
    logic [63:0] m;
    m = 64'h0000_0000_FFFF_FFFF;
    if (id >= STEP_EID_FRST && id <= STEP_EID_LAST) begin
      m = 64'h0000_0000_0000_FFFF;
    end else if (id == STEP_TIME || id == STEP_LIFE) begin
      m = '1;
    end
    return m;
  endfunction

endpackage

// ===== src/bpb_front.sv =====
// ----------------------------------------------------------------------------
// bpb_front: byte classifier and SDNV decoder
// Tracks the field step, accumulates SDNV groups and pushes one record
// into the result queue for every completed field or dictionary byte.
// ----------------------------------------------------------------------------
module bpb_front #(
  parameter int VALUE_WIDTH = bpb_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bpb_pkg::bpb_in_t   in_data,
  input  bpb_pkg::bpb_qstat_t qstat,
  output logic               push,
  output bpb_pkg::bpb_out_t  push_data
);
  import bpb_pkg::*;

  logic [4:0]             step_r, step_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [31:0]            rem_r, rem_nxt;
  logic [31:0]            pos_r, pos_nxt;
  logic [31:0]            total_r, total_nxt;

  logic                   take;
  logic                   restart;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic                   ovf_step;
  logic [63:0]            val64;

  assign take    = in_valid && !qstat.full;
  assign restart = in_data.start_of_header || step_r == STEP_VERSION
                   || step_r > STEP_ADULEN;

  always_comb begin
    ovf_step = ovf_r || (acc_r[VALUE_WIDTH-1 -: 7] != 7'd0);
    acc_step = ovf_step ? '1 : {acc_r[VALUE_WIDTH-8:0], in_data.data_byte[6:0]};
    val64    = 64'(acc_step) & field_mask(step_r);
  end

  always_comb begin
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    push      = 1'b0;
    push_data = '0;
    if (take) begin
      if (restart) begin
        step_nxt  = STEP_FLAGS;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        rem_nxt   = '0;
        pos_nxt   = '0;
        total_nxt = 32'd1;
        push      = 1'b1;
        push_data.field_id     = STEP_VERSION;
        push_data.field_value  = 64'(in_data.data_byte);
        push_data.header_bytes = 32'd1;
      end else if (step_r == STEP_DICTBYTE) begin
        total_nxt = total_r + 32'd1;
        pos_nxt   = pos_r + 32'd1;
        rem_nxt   = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          step_nxt = STEP_FRAGOFF;
        end
        push = 1'b1;
        push_data.field_id     = STEP_DICTBYTE;
        push_data.field_value  = 64'(in_data.data_byte);
        push_data.dict_index   = pos_r;
        push_data.header_bytes = total_r + 32'd1;
      end else begin
        total_nxt = total_r + 32'd1;
        if (in_data.data_byte[7]) begin
          acc_nxt = acc_step;
          ovf_nxt = ovf_step;
        end else begin
          // Last group of the number: emit and move to the next field.
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          push    = 1'b1;
          push_data.field_id     = step_r;
          push_data.field_value  = val64;
          push_data.too_long     = ovf_step;
          push_data.header_done  = (step_r == STEP_ADULEN);
          push_data.header_bytes = total_r + 32'd1;
          if (step_r == STEP_DICTLEN) begin
            rem_nxt  = val64[31:0];
            pos_nxt  = '0;
            step_nxt = (val64[31:0] == 32'd0) ? STEP_FRAGOFF : STEP_DICTBYTE;
          end else if (step_r == STEP_ADULEN) begin
            step_nxt = STEP_VERSION;
          end else begin
            step_nxt = step_r + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_VERSION;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      rem_r   <= '0;
      pos_r   <= '0;
      total_r <= '0;
    end else begin
      step_r  <= step_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// ===== src/bpb_queue.sv =====
// ----------------------------------------------------------------------------
// bpb_queue: short result queue
// Small FIFO between the decoder and the output stage.
// ----------------------------------------------------------------------------
module bpb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bpb_pkg::bpb_out_t   push_data,
  input  logic                pop,
  output bpb_pkg::bpb_out_t   head,
  output bpb_pkg::bpb_qstat_t qstat
);
  import bpb_pkg::*;

  bpb_out_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt;
  logic [QPTR_W-1:0]   rd_r, rd_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head        = mem[rd_r];
  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);

endmodule

// ===== src/bpb_back.sv =====
// ----------------------------------------------------------------------------
// bpb_back: result output stage
// Pops queued records into the output register and holds them under stall.
// ----------------------------------------------------------------------------
module bpb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bpb_pkg::bpb_qstat_t qstat,
  input  bpb_pkg::bpb_out_t   head,
  output logic                pop,
  output logic                out_valid,
  output bpb_pkg::bpb_out_t   out_data,
  input  logic                out_stall
);
  import bpb_pkg::*;

  logic     valid_r, valid_nxt;
  bpb_out_t data_r;

  // The register is free when empty or when its request leaves this cycle.
  assign pop       = !qstat.empty && (!valid_r || !out_stall);
  assign valid_nxt = pop || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/bundle_primary_block_parser.sv =====
// ----------------------------------------------------------------------------
// bundle_primary_block_parser: bundle protocol v6 primary block parser
// Decodes the version byte, the SDNV fields and the dictionary bytes of a
// primary block byte stream and emits one request per completed field.
// ----------------------------------------------------------------------------
// A completed field's result passes through the queue into the output register.
// Throughput: one byte per cycle unless in_stall (combinational SDNV shift-or).
// A two-entry queue separates the decoder from the output register.
// Reset is synchronous and active low; it returns the parser to the version
// byte and empties the queue and the output register.
module bundle_primary_block_parser #(
  parameter int VALUE_WIDTH = bpb_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bpb_pkg::bpb_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output bpb_pkg::bpb_out_t out_data,
  input  logic              out_stall
);
  import bpb_pkg::*;

  bpb_qstat_t qstat;
  logic       push;
  logic       pop;
  bpb_out_t   push_data;
  bpb_out_t   head;

  assign in_stall = qstat.full;

  bpb_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .push_data(push_data)
  );

  bpb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  bpb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  // The decoder never writes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("push into full result queue");

  // The output stage never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty result queue");

  // Only the ADU length closes a header.
  a_done_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.header_done |-> out_data.field_id == STEP_ADULEN)
    else $error("header_done on wrong field");

  // Dictionary positions appear on dictionary bytes only.
  a_dict_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.field_id != STEP_DICTBYTE |-> out_data.dict_index == 32'd0)
    else $error("dict_index set on non-dictionary field");

endmodule

// ===== test/bundle_primary_block_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bundle_primary_block_parser_tb: self-checking bench for the primary block parser
// Feeds directed and random byte streams (well-formed headers, cut-off headers
// and noise) and checks every field request against a cycle-free decoder model.
// ----------------------------------------------------------------------------
module bundle_primary_block_parser_tb;
  import bpb_pkg::*;

  localparam int          VW            = 64;
  localparam logic [63:0] VALUE_MASK    = {64{1'b1}} >> (64 - VW);
  localparam int          RANDOM_BYTES  = 1650;
  localparam int          HOLD_SPACING  = 450;
  localparam int          HOLD_CYCLES   = 150;
  localparam int          HOLD_COUNT    = 3;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SHOW_LIMIT    = 10;

  typedef struct {
    bpb_in_t item;
    bit      drain;
  } byte_req_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  bpb_in_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  bpb_out_t out_data;
  logic     out_stall = 1'b0;

  byte_req_t  pending_reqs[$];
  bpb_out_t   expected_fields[$];
  logic [7:0] hdr_build[$];
  bit         drain_next;

  // Decoder model state.
  logic [4:0]  step_q;
  logic [63:0] acc_q;
  logic        ovf_q;
  logic [31:0] dict_left_q;
  logic [31:0] dict_pos_q;
  logic [31:0] hdr_count_q;

  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned fields_checked, headers_seen, dict_seen, oversized_seen;
  int unsigned fail_count;

  bit          tx_fire, tx_burst, rx_burst;
  int unsigned tx_gap, tx_gap_left, rx_wait, rx_wait_left;

  bundle_primary_block_parser #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] field_value_mask(input logic [4:0] id);
    if (id >= STEP_EID_FRST && id <= STEP_EID_LAST) return 64'h0000_0000_0000_FFFF;
    if (id == STEP_TIME || id == STEP_LIFE) return {64{1'b1}};
    return 64'h0000_0000_FFFF_FFFF;
  endfunction

  task automatic reset_decoder();
    step_q      = STEP_VERSION;
    acc_q       = '0;
    ovf_q       = 1'b0;
    dict_left_q = '0;
    dict_pos_q  = '0;
    hdr_count_q = '0;
  endtask

  // Advances the model by one accepted byte and queues the field it completes.
  task automatic decode_byte(input bpb_in_t item);
    bpb_out_t   r;
    logic [7:0] b;
    logic [4:0] id;
    b = item.data_byte;
    r = '0;
    if (item.start_of_header || step_q == STEP_VERSION || step_q > STEP_ADULEN) begin
      acc_q       = '0;
      ovf_q       = 1'b0;
      dict_left_q = '0;
      dict_pos_q  = '0;
      hdr_count_q = 32'd1;
      step_q      = STEP_FLAGS;
      r.field_id     = STEP_VERSION;
      r.field_value  = {56'd0, b};
      r.header_bytes = hdr_count_q;
      expected_fields.insert(expected_fields.size(), r);
      return;
    end
    hdr_count_q = hdr_count_q + 32'd1;
    if (step_q == STEP_DICTBYTE) begin
      r.field_id     = STEP_DICTBYTE;
      r.field_value  = {56'd0, b};
      r.dict_index   = dict_pos_q;
      r.header_bytes = hdr_count_q;
      expected_fields.insert(expected_fields.size(), r);
      dict_pos_q  = dict_pos_q + 32'd1;
      dict_left_q = dict_left_q - 32'd1;
      if (dict_left_q == 32'd0) step_q = STEP_FRAGOFF;
      return;
    end
    // Once a further group no longer fits, the number sticks at all ones.
    if (ovf_q || (acc_q >> (VW - 7)) != 64'd0) begin
      ovf_q = 1'b1;
      acc_q = VALUE_MASK;
    end else begin
      acc_q = ((acc_q << 7) | {57'd0, b[6:0]}) & VALUE_MASK;
    end
    if (b[7]) return;
    id = step_q;
    r.field_id     = id;
    r.field_value  = acc_q & field_value_mask(id);
    r.too_long     = ovf_q;
    r.header_done  = (id == STEP_ADULEN);
    r.header_bytes = hdr_count_q;
    expected_fields.insert(expected_fields.size(), r);
    acc_q = '0;
    ovf_q = 1'b0;
    if (id == STEP_DICTLEN) begin
      dict_left_q = r.field_value[31:0];
      dict_pos_q  = '0;
      step_q      = (dict_left_q == 32'd0) ? STEP_FRAGOFF : STEP_DICTBYTE;
    end else if (id == STEP_ADULEN) begin
      step_q = STEP_VERSION;
    end else begin
      step_q = id + 5'd1;
    end
  endtask

  task automatic check_field(input bpb_out_t got);
    bpb_out_t want;
    if (expected_fields.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT) begin
        $display("ERROR: unexpected field id=%0d value=%h at cycle %0d",
                 got.field_id, got.field_value, cycle_count);
      end
      return;
    end
    want = expected_fields.pop_front();
    fields_checked++;
    if (want.header_done) headers_seen++;
    if (want.field_id == STEP_DICTBYTE) dict_seen++;
    if (want.too_long) oversized_seen++;
    if (got.field_id !== want.field_id || got.field_value !== want.field_value ||
        got.dict_index !== want.dict_index || got.too_long !== want.too_long ||
        got.header_done !== want.header_done || got.header_bytes !== want.header_bytes) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT) begin
        $display("ERROR: field mismatch at cycle %0d", cycle_count);
        $display("  expected id=%0d value=%h index=%0d long=%0b done=%0b bytes=%0d",
                 want.field_id, want.field_value, want.dict_index, want.too_long,
                 want.header_done, want.header_bytes);
        $display("  actual   id=%0d value=%h index=%0d long=%0b done=%0b bytes=%0d",
                 got.field_id, got.field_value, got.dict_index, got.too_long,
                 got.header_done, got.header_bytes);
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic sof);
    byte_req_t req;
    req.item.data_byte       = b;
    req.item.start_of_header = sof;
    req.drain                = drain_next;
    drain_next = 1'b0;
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  function automatic logic [63:0] random_value();
    int unsigned bits;
    logic [63:0] v;
    bits = $urandom_range(0, 64);
    v    = {$urandom, $urandom};
    if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
    return v;
  endfunction

  function automatic int unsigned random_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Appends one number in 7-bit groups, optionally behind zero groups or
  // behind an extra nonzero group that makes it too long.
  task automatic build_number(input logic [63:0] val, input int unsigned pad,
                              input bit oversize);
    int         groups;
    int         i;
    logic [6:0] grp;
    groups = 1;
    for (i = 1; i < 10; i++) begin
      if ((val >> (7 * i)) != 64'd0) groups = i + 1;
    end
    repeat (pad) hdr_build.insert(hdr_build.size(), 8'h80);
    if (oversize) begin
      hdr_build.insert(hdr_build.size(), 8'h80 | 8'($urandom_range(1, 127)));
      groups = 10;
    end
    for (i = groups - 1; i >= 0; i--) begin
      grp = 7'(val >> (7 * i));
      hdr_build.insert(hdr_build.size(), {(i != 0), grp});
    end
  endtask

  task automatic build_header();
    int          id;
    int unsigned dict_len;
    logic [63:0] len_field;
    hdr_build.delete();
    hdr_build.insert(hdr_build.size(), 8'($urandom_range(0, 255)));
    for (id = STEP_FLAGS; id <= STEP_LIFE; id++) begin
      build_number(random_value(), random_pad(), $urandom_range(0, 19) == 0);
    end
    dict_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
    // Upper bits are dropped by the 32-bit cast, so only the low word counts.
    len_field = {($urandom_range(0, 3) == 0) ? $urandom : 32'd0, dict_len};
    build_number(len_field, random_pad(), 1'b0);
    repeat (dict_len) hdr_build.insert(hdr_build.size(), 8'($urandom_range(0, 255)));
    build_number(random_value(), random_pad(), $urandom_range(0, 19) == 0);
    build_number(random_value(), random_pad(), $urandom_range(0, 19) == 0);
  endtask

  task automatic queue_header(input logic sof, input int unsigned keep);
    int unsigned i;
    for (i = 0; i < keep; i++) queue_byte(hdr_build[i], (i == 0) ? sof : 1'b0);
  endtask

  // Sender: one request at a time from the pending queue, random gaps between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      tx_gap_left <= 0;
      reset_decoder();
    end else begin
      tx_fire = in_valid && !in_stall;
      tx_gap  = tx_gap_left;
      if (tx_fire) begin
        decode_byte(in_data);
        bytes_sent <= bytes_sent + 1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 12);
      end
      if (in_valid && !tx_fire) begin
        // Stalled: the request stays on the bus unchanged.
      end else if (tx_gap != 0) begin
        in_valid    <= 1'b0;
        tx_gap_left <= tx_gap - 1;
      end else if (pending_reqs.size() != 0 &&
                   (!pending_reqs[0].drain || expected_fields.size() == 0)) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs[0].item;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs, spaced by the number of bytes sent.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < HOLD_COUNT && bytes_sent >= HOLD_SPACING * (holds_done + 1)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: checks each accepted result, then stalls for a random while.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      rx_wait_left <= 0;
    end else begin
      rx_wait = rx_wait_left;
      if (out_valid && !out_stall) begin
        check_field(out_data);
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
      end
      if (rx_wait != 0) begin
        out_stall    <= 1'b1;
        rx_wait_left <= rx_wait - 1;
      end else begin
        out_stall    <= (hold_left != 0);
        rx_wait_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("bundle_primary_block_parser verification failed");
      $finish;
    end
  end

  initial begin
    int          id;
    int unsigned sel;
    int unsigned total;
    bit          prev_done;
    bit          first_random;

    // Directed: a minimal header opened without a start flag, then a second
    // header back to back, a restart mid-field and an unterminated number.
    queue_byte(8'h00, 1'b0);
    for (id = STEP_FLAGS; id <= STEP_LIFE; id++) begin
      queue_byte((id == STEP_FLAGS) ? 8'h7F : 8'(id), 1'b0);
    end
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h06, 1'b1);
    repeat (3) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h06, 1'b1);

    total        = pending_reqs.size() + RANDOM_BYTES;
    prev_done    = 1'b0;
    first_random = 1'b1;
    while (pending_reqs.size() < total) begin
      sel = $urandom_range(0, 99);
      if (first_random || $urandom_range(0, 49) == 0) drain_next = 1'b1;
      first_random = 1'b0;
      build_header();
      if (sel < 75) begin
        queue_header(prev_done ? 1'($urandom_range(0, 1)) : 1'b1, hdr_build.size());
        prev_done = 1'b1;
      end else if (sel < 88) begin
        queue_header(1'b1, $urandom_range(1, hdr_build.size() - 1));
        prev_done = 1'b0;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        prev_done = 1'b0;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_fields.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_fields.size() != 0) begin
      $display("ERROR: %0d expected fields never arrived", expected_fields.size());
      fail_count += expected_fields.size();
    end
    $display("Run covered %0d bytes and %0d checked fields: %0d complete headers,",
             bytes_sent, fields_checked, headers_seen);
    $display("  %0d dictionary bytes, %0d oversized numbers, %0d long receiver holds.",
             dict_seen, oversized_seen, holds_done);
    if (fail_count == 0) begin
      $display("bundle_primary_block_parser verification clean");
    end else begin
      $display("bundle_primary_block_parser verification failed");
    end
    $finish;
  end

endmodule
